// ===== src/lphs_pkg.sv =====
// lphs_pkg: shared types, constants and hash/slot helpers for the hash set unit
// used by lphs_ctrl, lphs_datapath, linear_probe_hash_set_unit and lphs_checker
package lphs_pkg;

    // table geometry; the slot count is a power of two
    localparam int SLOT_COUNT = 4096;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int PROBE_W    = SLOT_W + 1;
    localparam int EXT_W      = (PROBE_W > 12) ? PROBE_W : 12;
    localparam int HALF_COUNT = SLOT_COUNT / 2;

    localparam logic [63:0] KEY_INVALID = '1;
    localparam logic [1:0]  HASH_FIRST  = 2'd0;
    localparam logic [1:0]  HASH_LAST   = 2'd3;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_IDLE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // how an item ends
    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_INVALID,
        FIN_FULL,
        FIN_REMOVE,
        FIN_INSERT,
        FIN_FOUND,
        FIN_ABSENT,
        FIN_EXHAUST
    } t_fin;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [11:0] slot_index;
        logic [11:0] probe_steps;
        logic [11:0] stored_count;
    } t_out_item;

    typedef struct packed {
        logic       latch_in;
        logic       clr_write;
        logic       hash_step;
        logic [1:0] hash_round;
        logic       probe_start;
        logic       probe_advance;
        logic       remove_write;
        logic       insert_write;
        logic       res_load;
        t_fin       fin;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       clr_last;
        logic       key_invalid;
        logic       table_full;
        logic       exhausted;
        logic       slot_empty;
        logic       slot_match;
    } t_stat;

    // one round of the 64-bit shift-add-xor mix
    function automatic logic [63:0] hash_round(input logic [63:0] k, input logic [1:0] rnd);
        logic [63:0] t;
        logic [63:0] r;
        t = '0;
        case (rnd)
            2'd0: begin
                t = ~k + (k << 21);
                r = t ^ (t >> 24);
            end
            2'd1: begin
                t = k + (k << 3) + (k << 8);
                r = t ^ (t >> 14);
            end
            2'd2: begin
                t = k + (k << 2) + (k << 4);
                r = t ^ (t >> 28);
            end
            default: begin
                r = k + (k << 31);
            end
        endcase
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [11:0] low12(input logic [PROBE_W-1:0] v);
        logic [EXT_W-1:0] w;
        w = EXT_W'(v);
        return w[11:0];
    endfunction

    function automatic logic [11:0] sat12(input logic [PROBE_W-1:0] v);
        logic [EXT_W-1:0] w;
        w = EXT_W'(v);
        return (w > EXT_W'(12'hFFF)) ? 12'hFFF : w[11:0];
    endfunction

endpackage

// ===== src/lphs_datapath.sv =====
// lphs_datapath: slot memory, hash register, probe pointer, counters and result registers
// depends on lphs_pkg; driven by commands from lphs_ctrl
module lphs_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lphs_pkg::t_cmd      i_cmd,
    input  lphs_pkg::t_in_item  i_in_item,
    output lphs_pkg::t_stat     o_stat,
    output lphs_pkg::t_out_item o_out_item
);

    logic [63:0] r_slot_store [lphs_pkg::SLOT_COUNT];
    logic [63:0] r_rd_data;

    logic [1:0]                   r_action;
    logic [63:0]                  r_key;
    logic [63:0]                  r_hash;
    logic [lphs_pkg::SLOT_W-1:0]  r_slot;
    logic [lphs_pkg::PROBE_W-1:0] r_n;
    logic [lphs_pkg::SLOT_W-1:0]  r_count;
    logic [lphs_pkg::SLOT_W-1:0]  r_last;
    logic [lphs_pkg::SLOT_W-1:0]  r_clr_addr;
    lphs_pkg::t_out_item          r_res;
    lphs_pkg::t_out_item          r_out;

    logic [63:0]                 tag;
    logic [63:0]                 hashed;
    logic [lphs_pkg::SLOT_W-1:0] home;
    logic [lphs_pkg::SLOT_W-1:0] slot_next;
    logic [lphs_pkg::SLOT_W-1:0] rd_addr;
    logic                        we;
    logic [lphs_pkg::SLOT_W-1:0] waddr;
    logic [63:0]                 wdata;
    logic [lphs_pkg::SLOT_W-1:0] n_count;
    lphs_pkg::t_out_item         res;

    assign tag       = r_key + 64'd1;
    assign hashed    = lphs_pkg::hash_round(r_hash, i_cmd.hash_round);
    assign home      = hashed[lphs_pkg::SLOT_W-1:0];
    assign slot_next = lphs_pkg::next_slot(r_slot);
    assign rd_addr   = i_cmd.probe_start ? home : slot_next;
    assign n_count   = i_cmd.insert_write ? r_count + lphs_pkg::SLOT_W'(1) : r_count;

    always_comb begin
        we    = 1'b0;
        waddr = r_slot;
        wdata = '0;
        if (i_cmd.clr_write) begin
            we    = 1'b1;
            waddr = r_clr_addr;
        end else if (i_cmd.remove_write) begin
            we    = 1'b1;
            waddr = r_last;
        end else if (i_cmd.insert_write) begin
            we    = 1'b1;
            wdata = tag;
        end
    end

    always_comb begin
        res              = '0;
        res.status       = lphs_pkg::ST_OK;
        res.stored_count = lphs_pkg::low12({1'b0, n_count});
        case (i_cmd.fin)
            lphs_pkg::FIN_INVALID: res.status = lphs_pkg::ST_INVALID;
            lphs_pkg::FIN_FULL:    res.status = lphs_pkg::ST_FULL;
            lphs_pkg::FIN_REMOVE:  res.slot_index = lphs_pkg::low12({1'b0, r_last});
            lphs_pkg::FIN_INSERT: begin
                res.slot_index  = lphs_pkg::low12({1'b0, r_slot});
                res.probe_steps = lphs_pkg::sat12(r_n);
            end
            lphs_pkg::FIN_FOUND: begin
                res.found       = 1'b1;
                res.slot_index  = lphs_pkg::low12({1'b0, r_slot});
                res.probe_steps = lphs_pkg::sat12(r_n);
            end
            lphs_pkg::FIN_ABSENT:  res.probe_steps = lphs_pkg::sat12(r_n);
            lphs_pkg::FIN_EXHAUST: begin
                // no empty slot anywhere: insert is refused, lookup misses
                if (r_action == lphs_pkg::ACT_INSERT) begin
                    res.status = lphs_pkg::ST_FULL;
                end
            end
            default: res.status = lphs_pkg::ST_OK;
        endcase
    end

    always_comb begin
        o_stat             = '0;
        o_stat.action      = r_action;
        o_stat.clr_last    = (r_clr_addr == lphs_pkg::SLOT_W'(lphs_pkg::SLOT_COUNT - 1));
        o_stat.key_invalid = (r_key == lphs_pkg::KEY_INVALID);
        o_stat.table_full  = ({1'b0, r_count} >= lphs_pkg::PROBE_W'(lphs_pkg::HALF_COUNT));
        o_stat.exhausted   = (r_n == lphs_pkg::PROBE_W'(lphs_pkg::SLOT_COUNT));
        o_stat.slot_empty  = (r_rd_data == 64'd0);
        o_stat.slot_match  = (r_rd_data == tag);
    end

    // slot memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_slot_store[waddr] <= wdata;
        end
        r_rd_data <= r_slot_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_action <= i_in_item.action;
            r_key    <= i_in_item.key;
            r_hash   <= i_in_item.key;
        end else if (i_cmd.hash_step) begin
            r_hash <= hashed;
        end
        if (i_cmd.probe_start) begin
            r_slot <= home;
            r_n    <= '0;
        end else if (i_cmd.probe_advance) begin
            r_slot <= slot_next;
            r_n    <= r_n + lphs_pkg::PROBE_W'(1);
        end
        if (i_cmd.res_load) begin
            r_res <= res;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_count    <= '0;
            r_last     <= '0;
        end else begin
            if (i_cmd.clr_write) begin
                r_clr_addr <= r_clr_addr + lphs_pkg::SLOT_W'(1);
            end
            if (i_cmd.insert_write) begin
                r_count <= n_count;
                r_last  <= r_slot;
            end
        end
    end

    assign o_out_item = r_out;

endmodule

// ===== src/lphs_ctrl.sv =====
// lphs_ctrl: sequencer for clearing, hashing, probing and result hand-off
// depends on lphs_pkg; commands lphs_datapath
module lphs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  lphs_pkg::t_stat i_stat,
    output lphs_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_FINISH
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_round, n_round;
    logic       r_out_valid, n_out_valid;
    logic       probe_action;

    assign probe_action = (i_stat.action == lphs_pkg::ACT_INSERT)
                       || (i_stat.action == lphs_pkg::ACT_LOOKUP);

    always_comb begin
        o_cmd            = '0;
        o_cmd.fin        = lphs_pkg::FIN_NONE;
        o_cmd.hash_round = r_round;
        n_state          = r_state;
        n_round          = r_round;
        n_out_valid      = r_out_valid && !i_out_ready;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_round        = lphs_pkg::HASH_FIRST;
                    n_state        = S_HASH;
                end
            end
            S_HASH: begin
                if (r_round == lphs_pkg::HASH_FIRST && probe_action && i_stat.key_invalid) begin
                    o_cmd.fin      = lphs_pkg::FIN_INVALID;
                    o_cmd.res_load = 1'b1;
                    n_state        = S_FINISH;
                end else if (r_round == lphs_pkg::HASH_FIRST
                             && i_stat.action == lphs_pkg::ACT_INSERT && i_stat.table_full) begin
                    o_cmd.fin      = lphs_pkg::FIN_FULL;
                    o_cmd.res_load = 1'b1;
                    n_state        = S_FINISH;
                end else if (r_round == lphs_pkg::HASH_FIRST && !probe_action) begin
                    // remove-last clears its slot here, the unused action does nothing
                    o_cmd.remove_write = (i_stat.action == lphs_pkg::ACT_REMOVE);
                    o_cmd.fin          = (i_stat.action == lphs_pkg::ACT_REMOVE)
                                       ? lphs_pkg::FIN_REMOVE : lphs_pkg::FIN_NONE;
                    o_cmd.res_load     = 1'b1;
                    n_state            = S_FINISH;
                end else begin
                    o_cmd.hash_step = 1'b1;
                    if (r_round == lphs_pkg::HASH_LAST) begin
                        o_cmd.probe_start = 1'b1;
                        n_state           = S_PROBE;
                    end else begin
                        n_round = r_round + 2'd1;
                    end
                end
            end
            S_PROBE: begin
                // read data belongs to the current slot; the next slot is read speculatively
                if (i_stat.exhausted) begin
                    o_cmd.fin      = lphs_pkg::FIN_EXHAUST;
                    o_cmd.res_load = 1'b1;
                    n_state        = S_FINISH;
                end else if (i_stat.slot_empty) begin
                    o_cmd.insert_write = (i_stat.action == lphs_pkg::ACT_INSERT);
                    o_cmd.fin          = (i_stat.action == lphs_pkg::ACT_INSERT)
                                       ? lphs_pkg::FIN_INSERT : lphs_pkg::FIN_ABSENT;
                    o_cmd.res_load     = 1'b1;
                    n_state            = S_FINISH;
                end else if (i_stat.action == lphs_pkg::ACT_LOOKUP && i_stat.slot_match) begin
                    o_cmd.fin      = lphs_pkg::FIN_FOUND;
                    o_cmd.res_load = 1'b1;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.probe_advance = 1'b1;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_round     <= lphs_pkg::HASH_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/linear_probe_hash_set_unit.sv =====
// linear_probe_hash_set_unit: top level of the linear-probing hash set
// depends on lphs_pkg, lphs_ctrl and lphs_datapath
//
// Hash set of 64-bit keys in SLOT_COUNT (4096) slots held in one single-port-write,
// registered-read memory. After reset the block sweeps the memory to empty, one slot per
// cycle, with o_in_ready low until the sweep ends. An insert or lookup then passes through
// an accept step, the iterated 64-bit hash rounds, the probe from the home slot on (the
// memory read port delivers one slot per cycle) and a hand-off step. Remove-last, inserts
// refused on a full table, invalid keys and the unused action are settled in the first
// hash step and go straight to the hand-off. The result sits in an output register, so
// the next beat is taken while a finished result waits on i_out_ready.
module linear_probe_hash_set_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lphs_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lphs_pkg::t_out_item o_out_item
);

    lphs_pkg::t_cmd  cmd;
    lphs_pkg::t_stat stat;

    lphs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lphs_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .o_stat     (stat),
        .o_out_item (o_out_item)
    );

endmodule

// ===== src/lphs_checker.sv =====
// lphs_checker: port-level assertions for linear_probe_hash_set_unit, bound to the top
// depends on lphs_pkg
module lphs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input lphs_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input lphs_pkg::t_out_item o_out_item
);

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result beat dropped or changed while stalled");

    // one item at a time: ready falls right after an accepted beat
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready stayed high after an accepted beat");

    // refused or invalid results carry no slot, probe count or hit
    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == lphs_pkg::ST_INVALID
                        || o_out_item.status == lphs_pkg::ST_FULL)
        |-> !o_out_item.found && o_out_item.slot_index == 12'd0
            && o_out_item.probe_steps == 12'd0)
        else $error("refused result carries slot data");

    // a hit is always an ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.found |-> o_out_item.status == lphs_pkg::ST_OK)
        else $error("hit reported with error status");

    // nothing comes out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("handshake active right after reset");

endmodule

bind linear_probe_hash_set_unit lphs_checker u_lphs_checker (.*);

// ===== bench/linear_probe_hash_set_unit_tb.sv =====
`timescale 1ns / 1ps
// linear_probe_hash_set_unit_tb: self-checking bench for the hash set unit, with its own
// table predictor, directed and random beats, and a scoreboard; depends on lphs_pkg and linear_probe_hash_set_unit
module linear_probe_hash_set_unit_tb;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 64;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 200;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_MASK
    } t_rx_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_ready;
    lphs_pkg::t_in_item  in_item;
    logic                out_valid;
    logic                out_ready;
    lphs_pkg::t_out_item out_item;

    // shadow of the slot table and its bookkeeping
    logic [63:0]                 slot_tab [lphs_pkg::SLOT_COUNT];
    int unsigned                 live_count;
    logic [lphs_pkg::SLOT_W-1:0] last_slot;

    lphs_pkg::t_out_item awaited_results [$];
    logic [63:0]         stored_keys [$];

    int unsigned         err_cnt = 0;
    int unsigned         cycle_cnt = 0;
    int unsigned         hold_asks = 0;
    int unsigned         burst_left;
    bit                  gaps_on;
    int unsigned n_beats, n_stored, n_hits, n_misses, n_full, n_bad, n_clears, deepest;
    lphs_pkg::t_out_item want;

    linear_probe_hash_set_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // 64-bit shift-add-xor mix, masked to a slot number
    function automatic logic [lphs_pkg::SLOT_W-1:0] home_of(input logic [63:0] k);
        logic [63:0] h;
        h = ~k + (k << 21);
        h = h ^ (h >> 24);
        h = h + (h << 3) + (h << 8);
        h = h ^ (h >> 14);
        h = h + (h << 2) + (h << 4);
        h = h ^ (h >> 28);
        h = h + (h << 31);
        return h[lphs_pkg::SLOT_W-1:0];
    endfunction

    // updates the shadow table for one accepted beat and returns the result it owes
    function automatic lphs_pkg::t_out_item apply_to_table(input lphs_pkg::t_in_item it);
        lphs_pkg::t_out_item         r;
        logic [63:0]                 tag;
        logic [lphs_pkg::SLOT_W-1:0] s;
        int unsigned                 n;
        bit                          done;
        r = '0;
        case (it.action)
            lphs_pkg::ACT_INSERT, lphs_pkg::ACT_LOOKUP: begin
                if (it.key == lphs_pkg::KEY_INVALID) begin
                    r.status = lphs_pkg::ST_INVALID;
                    n_bad++;
                end else if (it.action == lphs_pkg::ACT_INSERT
                             && live_count >= lphs_pkg::HALF_COUNT) begin
                    r.status = lphs_pkg::ST_FULL;
                    n_full++;
                end else begin
                    tag  = it.key + 64'd1;
                    s    = home_of(it.key);
                    n    = 0;
                    done = 1'b0;
                    while (!done && n < lphs_pkg::SLOT_COUNT) begin
                        if (slot_tab[s] == '0) begin
                            if (it.action == lphs_pkg::ACT_INSERT) begin
                                slot_tab[s]   = tag;
                                last_slot     = s;
                                live_count++;
                                r.slot_index  = 12'(s);
                                n_stored++;
                            end else begin
                                n_misses++;
                            end
                            done = 1'b1;
                        end else if (it.action == lphs_pkg::ACT_LOOKUP
                                     && slot_tab[s] == tag) begin
                            r.found      = 1'b1;
                            r.slot_index = 12'(s);
                            n_hits++;
                            done = 1'b1;
                        end else begin
                            s = (s == lphs_pkg::SLOT_W'(lphs_pkg::SLOT_COUNT - 1))
                              ? '0 : s + lphs_pkg::SLOT_W'(1);
                            n++;
                        end
                    end
                    if (it.action == lphs_pkg::ACT_INSERT && !done) begin
                        r.status = lphs_pkg::ST_FULL;
                    end else if (done) begin
                        r.probe_steps = (n > 4095) ? 12'hFFF : 12'(n);
                        if (n > deepest) deepest = n;
                    end
                end
            end
            lphs_pkg::ACT_REMOVE: begin
                slot_tab[last_slot] = '0;
                r.slot_index = 12'(last_slot);
                n_clears++;
            end
            default: begin
            end
        endcase
        r.stored_count = 12'(live_count);
        return r;
    endfunction

    function automatic logic [63:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 6) return 64'($urandom_range(0, 15));
        if (roll < 10) return lphs_pkg::KEY_INVALID - 64'($urandom_range(1, 8));
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] key_with_home(input logic [lphs_pkg::SLOT_W-1:0] target);
        logic [63:0] k;
        k = {$urandom, $urandom};
        while (home_of(k) != target || k == lphs_pkg::KEY_INVALID) k = {$urandom, $urandom};
        return k;
    endfunction

    // one beat on the input side; with gaps_on set the sender runs in bursts with random gaps between them
    task automatic send_item(input logic [1:0] act, input logic [63:0] key);
        lphs_pkg::t_in_item it;
        int unsigned        gap;
        it.action = act;
        it.key    = key;
        gap       = 0;
        @(negedge i_clk);
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(0, 10);
            end
            burst_left--;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        awaited_results.push_back(apply_to_table(it));
        n_beats++;
    endtask

    task automatic test_edge_cases();
        logic [63:0] near_top;
        near_top = lphs_pkg::KEY_INVALID - 64'd1;
        // remove-last before any insert hits slot 0, twice, and ignores its key
        send_item(lphs_pkg::ACT_REMOVE, 64'd0);
        send_item(lphs_pkg::ACT_REMOVE, lphs_pkg::KEY_INVALID);
        send_item(lphs_pkg::ACT_IDLE, {$urandom, $urandom});
        send_item(lphs_pkg::ACT_INSERT, lphs_pkg::KEY_INVALID);
        send_item(lphs_pkg::ACT_LOOKUP, lphs_pkg::KEY_INVALID);
        send_item(lphs_pkg::ACT_INSERT, 64'd0);
        send_item(lphs_pkg::ACT_LOOKUP, 64'd0);
        send_item(lphs_pkg::ACT_INSERT, near_top);
        send_item(lphs_pkg::ACT_LOOKUP, near_top);
        send_item(lphs_pkg::ACT_LOOKUP, 64'd77);
        // duplicate insert lands one further; removing it leaves the first copy
        send_item(lphs_pkg::ACT_INSERT, 64'd0);
        send_item(lphs_pkg::ACT_REMOVE, 64'd0);
        send_item(lphs_pkg::ACT_LOOKUP, 64'd0);
    endtask

    task automatic test_collisions();
        logic [63:0] a, b, c, w1, w2;
        a  = 64'h0123_4567_89ab_cdef;
        b  = key_with_home(home_of(a));
        c  = key_with_home(home_of(a));
        w1 = key_with_home(lphs_pkg::SLOT_W'(lphs_pkg::SLOT_COUNT - 1));
        w2 = key_with_home(lphs_pkg::SLOT_W'(lphs_pkg::SLOT_COUNT - 1));
        send_item(lphs_pkg::ACT_INSERT, a);
        send_item(lphs_pkg::ACT_INSERT, b);
        send_item(lphs_pkg::ACT_INSERT, c);
        send_item(lphs_pkg::ACT_LOOKUP, c);
        send_item(lphs_pkg::ACT_REMOVE, 64'd0);
        send_item(lphs_pkg::ACT_LOOKUP, c);
        send_item(lphs_pkg::ACT_LOOKUP, b);
        // chain at the top slot wraps around to slot 0
        send_item(lphs_pkg::ACT_INSERT, w1);
        send_item(lphs_pkg::ACT_INSERT, w2);
        send_item(lphs_pkg::ACT_LOOKUP, w2);
        send_item(lphs_pkg::ACT_IDLE, lphs_pkg::KEY_INVALID);
    endtask

    task automatic test_random_mix(input int unsigned count);
        int unsigned roll;
        logic [63:0] k;
        for (int unsigned i = 0; i < count; i++) begin
            gaps_on = ((i / 40) % 3) != 2;
            if (i == 80) hold_asks++;
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                k = pick_key();
                if (k != lphs_pkg::KEY_INVALID && live_count < lphs_pkg::HALF_COUNT)
                    stored_keys.push_back(k);
                send_item(lphs_pkg::ACT_INSERT, k);
            end else if (roll < 83) begin
                if (stored_keys.size() > 0 && $urandom_range(0, 9) < 7)
                    k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                else
                    k = pick_key();
                send_item(lphs_pkg::ACT_LOOKUP, k);
            end else if (roll < 91) begin
                send_item(lphs_pkg::ACT_REMOVE, pick_key());
            end else if (roll < 95) begin
                send_item(lphs_pkg::ACT_IDLE, pick_key());
            end else begin
                send_item($urandom_range(0, 1) ? lphs_pkg::ACT_INSERT : lphs_pkg::ACT_LOOKUP,
                          lphs_pkg::KEY_INVALID);
            end
        end
        gaps_on = 1'b1;
    endtask

    // count never drops, so the half-full limit is reached by plain inserts
    task automatic test_half_full();
        logic [63:0] k;
        int unsigned i;
        i = 0;
        while (live_count < lphs_pkg::HALF_COUNT) begin
            if (i == 300) hold_asks++;
            k = pick_key();
            if (k != lphs_pkg::KEY_INVALID) stored_keys.push_back(k);
            if ($urandom_range(0, 15) == 0 && stored_keys.size() > 0)
                send_item(lphs_pkg::ACT_LOOKUP,
                          stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
            else
                send_item(lphs_pkg::ACT_INSERT, k);
            i++;
        end
        repeat (3) send_item(lphs_pkg::ACT_INSERT, {$urandom, $urandom});
        send_item(lphs_pkg::ACT_INSERT, lphs_pkg::KEY_INVALID);
        repeat (4) send_item(lphs_pkg::ACT_LOOKUP,
                             stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
        repeat (4) send_item(lphs_pkg::ACT_LOOKUP, {$urandom, $urandom});
        send_item(lphs_pkg::ACT_REMOVE, 64'd0);
        send_item(lphs_pkg::ACT_INSERT, 64'd5);
        send_item(lphs_pkg::ACT_IDLE, 64'd0);
    endtask

    task automatic check_field(input string what, input logic [11:0] exp_v,
                               input logic [11:0] got_v);
        if (got_v !== exp_v) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h got %0h", $time, what, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (awaited_results.size() == 0) begin
                err_cnt++;
                $display("%0t: result beat with none awaited, expected nothing got %h",
                         $time, out_item);
            end else begin
                want = awaited_results.pop_front();
                check_field("status", 12'(want.status), 12'(out_item.status));
                check_field("found", 12'(want.found), 12'(out_item.found));
                check_field("slot_index", want.slot_index, out_item.slot_index);
                check_field("probe_steps", want.probe_steps, out_item.probe_steps);
                check_field("stored_count", want.stored_count, out_item.stored_count);
            end
        end
    end

    // receiver: stall pattern of its own, plus an occasional long hold
    initial begin : rx_side
        t_rx_mode    mode;
        int unsigned phase_left;
        logic [15:0] mask;
        int unsigned holds_done;
        mode       = RX_STEADY;
        phase_left = 0;
        mask       = '1;
        holds_done = 0;
        out_ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asks != holds_done) begin
                out_ready <= 1'b0;
                for (int unsigned c = 1; c < LONG_HOLD; c++) @(negedge i_clk);
                holds_done++;
            end else begin
                if (phase_left == 0) begin
                    mode       = t_rx_mode'($urandom_range(0, 3));
                    phase_left = $urandom_range(16, 200);
                    mask       = 16'($urandom);
                end
                phase_left--;
                case (mode)
                    RX_STEADY: out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= mask[phase_left % 16];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
            $display("linear_probe_hash_set_unit_tb: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        burst_left    = 0;
        gaps_on       = 1'b1;
        n_beats       = 0;
        n_stored      = 0;
        n_hits        = 0;
        n_misses      = 0;
        n_full        = 0;
        n_bad         = 0;
        n_clears      = 0;
        deepest       = 0;
        live_count    = 0;
        last_slot     = '0;
        for (int i = 0; i < lphs_pkg::SLOT_COUNT; i++) slot_tab[i] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_edge_cases();
        test_collisions();
        test_random_mix(RANDOM_ITEMS);
        test_half_full();

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d beats: %0d stored, %0d hits, %0d misses, %0d clears",
                 n_beats, n_stored, n_hits, n_misses, n_clears);
        $display("refused %0d on half full, %0d invalid keys, longest probe walk %0d",
                 n_full, n_bad, deepest);
        if (err_cnt == 0) begin
            $display("linear_probe_hash_set_unit_tb: clean");
        end else begin
            $display("linear_probe_hash_set_unit_tb: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lphs_pkg.sv
src/lphs_datapath.sv
src/lphs_ctrl.sv
src/linear_probe_hash_set_unit.sv
src/lphs_checker.sv
bench/linear_probe_hash_set_unit_tb.sv
